// ----- hw/rtl/ssi_pkg.sv -----
package ssi_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int MAX_ITER         = 24;

    localparam logic signed [15:0] ONE_Q12 = 16'sd4096;

    // angle constants in q30 radians
    localparam logic [37:0] PI_Q30      = 38'd3373259426;
    localparam logic [37:0] HALF_PI_Q30 = 38'd1686629713;
    localparam logic [37:0] TWO_PI_Q30  = 38'd6746518852;
    localparam logic [37:0] TWO_PI_X2   = 38'd13493037704;
    localparam logic [37:0] TWO_PI_X4   = 38'd26986075408;

    // atan(2^-i) in q30, entry 0 is pi/4
    localparam logic [29:0] ATAN_Q30 [MAX_ITER] = '{
        30'd843314857, 30'd497837829, 30'd263043837, 30'd133525159,
        30'd67021687,  30'd33543516,  30'd16775851,  30'd8388437,
        30'd4194283,   30'd2097149,   30'd1048576,   30'd524288,
        30'd262144,    30'd131072,    30'd65536,     30'd32768,
        30'd16384,     30'd8192,      30'd4096,      30'd2048,
        30'd1024,      30'd512,       30'd256,       30'd128
    };

    typedef struct packed {
        logic signed [31:0] from_value;
        logic signed [31:0] to_value;
        logic signed [15:0] blend_weight;
        logic signed [15:0] arc_angle;
    } t_in;

    typedef struct packed {
        logic signed [31:0] blended_value;
        logic               sine_zero;
    } t_out;

endpackage

// ----- hw/rtl/scalar_spherical_interpolation_core.sv -----
// channel  | direction | handshake                 | payload
// in       | input     | i_in_valid / o_in_ready   | i_in_data  (ssi_pkg::t_in)
// out      | output    | o_out_valid / i_out_ready | o_out_data (ssi_pkg::t_out)
// cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (clamp_weight)
//
// one transaction per cycle in, one per cycle out while the output is not stalled;
// stages: 5 angle reduction stages, the cordic stages, 2 product stages, 34 divider stages
// synchronous active-low reset clears the valid bits and clamp_weight
// a result held on the output stalls the whole pipe, nothing is lost or repeated
module scalar_spherical_interpolation_core #(
    parameter int CORDIC_STEPS = ssi_pkg::CORDIC_STEPS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ssi_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ssi_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data
);

    localparam int NUSED = (CORDIC_STEPS > ssi_pkg::MAX_ITER) ? ssi_pkg::MAX_ITER
                                                              : CORDIC_STEPS;
    localparam int DL    = NUSED + 1;

    localparam logic signed [33:0] C_PI     = $signed(34'(ssi_pkg::PI_Q30));
    localparam logic signed [33:0] C_HALF   = $signed(34'(ssi_pkg::HALF_PI_Q30));
    localparam logic signed [33:0] C_TWO_PI = $signed(34'(ssi_pkg::TWO_PI_Q30));

    logic en;
    logic div_valid;

    assign en          = !div_valid || i_out_ready;
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;

    logic r_clamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clamp <= 1'b0;
        end else if (i_cfg_valid) begin
            r_clamp <= i_cfg_data;
        end
    end

    // stage 1: clamp and the three angles in q30
    logic signed [15:0] wc;
    logic signed [15:0] a_in;
    logic signed [17:0] omw;
    logic signed [37:0] prod_b;
    logic signed [37:0] prod_c;

    assign a_in = i_in_data.arc_angle;

    always_comb begin
        wc = i_in_data.blend_weight;
        if (r_clamp && (wc > ssi_pkg::ONE_Q12)) begin
            wc = ssi_pkg::ONE_Q12;
        end
        if (r_clamp && (wc < -ssi_pkg::ONE_Q12)) begin
            wc = -ssi_pkg::ONE_Q12;
        end
    end

    assign omw    = 18'(ssi_pkg::ONE_Q12) - 18'(wc);
    assign prod_b = 38'(omw) * 38'(a_in);
    assign prod_c = 38'(wc) * 38'(a_in);

    logic               r1_v;
    logic signed [31:0] r1_from;
    logic signed [31:0] r1_to;
    logic signed [37:0] r1_ang [3];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_from   <= i_in_data.from_value;
            r1_to     <= i_in_data.to_value;
            r1_ang[0] <= 38'(a_in) <<< 17;
            r1_ang[1] <= prod_b <<< 5;
            r1_ang[2] <= prod_c <<< 5;
        end
    end

    // stages 2..5: truncating remainder by 2*pi, wrap to -pi..pi, fold to -pi/2..pi/2
    logic               r2_v, r3_v, r4_v, r5_v;
    logic signed [31:0] r2_from, r3_from, r4_from, r5_from;
    logic signed [31:0] r2_to, r3_to, r4_to, r5_to;
    logic        [37:0] r2_mag [3];
    logic               r2_neg [3];
    logic        [32:0] r3_mag [3];
    logic               r3_neg [3];
    logic signed [33:0] r4_ang [3];
    logic signed [31:0] r5_ang [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic [37:0]        mag;
        logic [37:0]        m4;
        logic [37:0]        m2;
        logic [37:0]        m1;
        logic signed [33:0] mw;

        assign mag = r1_ang[l][37] ? 38'(-r1_ang[l]) : 38'(r1_ang[l]);
        assign m4  = (mag >= ssi_pkg::TWO_PI_X4) ? mag - ssi_pkg::TWO_PI_X4 : mag;
        assign m2  = ({5'd0, r2_mag[l]} >= {5'd0, ssi_pkg::TWO_PI_X2}) ?
                     r2_mag[l] - ssi_pkg::TWO_PI_X2 : r2_mag[l];
        assign m1  = (m2 >= ssi_pkg::TWO_PI_Q30) ? m2 - ssi_pkg::TWO_PI_Q30 : m2;
        assign mw  = ({5'd0, r3_mag[l]} > ssi_pkg::PI_Q30) ?
                     $signed({1'b0, r3_mag[l]}) - C_TWO_PI : $signed({1'b0, r3_mag[l]});

        always_ff @(posedge i_clk) begin
            if (en) begin
                r2_mag[l] <= m4;
                r2_neg[l] <= r1_ang[l][37];
                r3_mag[l] <= m1[32:0];
                r3_neg[l] <= r2_neg[l];
                r4_ang[l] <= r3_neg[l] ? -mw : mw;
                priority if (r4_ang[l] > C_HALF) begin
                    r5_ang[l] <= 32'(C_PI - r4_ang[l]);
                end else if (r4_ang[l] < -C_HALF) begin
                    r5_ang[l] <= 32'(-C_PI - r4_ang[l]);
                end else begin
                    r5_ang[l] <= 32'(r4_ang[l]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_from <= r1_from;
            r2_to   <= r1_to;
            r3_from <= r2_from;
            r3_to   <= r2_to;
            r4_from <= r3_from;
            r4_to   <= r3_to;
            r5_from <= r4_from;
            r5_to   <= r4_to;
        end
    end

    // three sines in parallel, endpoints ride alongside
    logic signed [31:0] sine [3];

    for (genvar l = 0; l < 3; l++) begin : g_cordic
        ssi_cordic #(
            .STEPS(CORDIC_STEPS)
        ) u_cordic (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_angle(r5_ang[l]),
            .o_sine (sine[l])
        );
    end

    logic               r_dl_v    [DL];
    logic signed [31:0] r_dl_from [DL];
    logic signed [31:0] r_dl_to   [DL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DL; k++) begin
                r_dl_v[k] <= 1'b0;
            end
        end else if (en) begin
            r_dl_v[0] <= r5_v;
            for (int k = 1; k < DL; k++) begin
                r_dl_v[k] <= r_dl_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl_from[0] <= r5_from;
            r_dl_to[0]   <= r5_to;
            for (int k = 1; k < DL; k++) begin
                r_dl_from[k] <= r_dl_from[k-1];
                r_dl_to[k]   <= r_dl_to[k-1];
            end
        end
    end

    // products, then their exact sum
    logic               r_m_v, r_n_v;
    logic signed [63:0] r_m_p1, r_m_p2;
    logic signed [31:0] r_m_sa, r_n_sa;
    logic               r_m_zero, r_n_zero;
    logic signed [63:0] r_n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
            r_n_v <= 1'b0;
        end else if (en) begin
            r_m_v <= r_dl_v[DL-1];
            r_n_v <= r_m_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_p1   <= 64'(r_dl_from[DL-1]) * 64'(sine[1]);
            r_m_p2   <= 64'(r_dl_to[DL-1]) * 64'(sine[2]);
            r_m_sa   <= sine[0];
            r_m_zero <= (sine[0] == '0);
            r_n_sum  <= r_m_p1 + r_m_p2;
            r_n_sa   <= r_m_sa;
            r_n_zero <= r_m_zero;
        end
    end

    ssi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_n_v),
        .i_zero  (r_n_zero),
        .i_num   (r_n_sum),
        .i_den   (r_n_sa),
        .o_valid (div_valid),
        .o_result(o_out_data)
    );

    assign o_out_valid = div_valid;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.sine_zero |-> o_out_data.blended_value == '0)
        else $error("zero sine transaction with nonzero result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input held off without an output stall");

    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

// ----- hw/rtl/ssi_cordic.sv -----
module ssi_cordic #(
    parameter int STEPS = ssi_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_angle,
    output logic signed [31:0] o_sine
);

    localparam int NUSED = (STEPS > ssi_pkg::MAX_ITER) ? ssi_pkg::MAX_ITER : STEPS;
    localparam int W     = 34;

    logic signed [W-1:0] r_x    [NUSED+1];
    logic signed [W-1:0] r_y    [NUSED+1];
    logic signed [W-1:0] r_z    [NUSED+1];
    logic                r_zero [NUSED+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= W'(34'sd536870912);
            r_y[0]    <= '0;
            r_z[0]    <= W'(i_angle);
            r_zero[0] <= (i_angle == '0);
        end
    end

    for (genvar i = 0; i < NUSED; i++) begin : g_step
        logic signed [W-1:0] xs;
        logic signed [W-1:0] ys;
        logic signed [W-1:0] t;

        assign xs = r_x[i] >>> i;
        assign ys = r_y[i] >>> i;
        assign t  = $signed(W'(ssi_pkg::ATAN_Q30[i]));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[i] >= 0) begin
                    r_x[i+1] <= r_x[i] - ys;
                    r_y[i+1] <= r_y[i] + xs;
                    r_z[i+1] <= r_z[i] - t;
                end else begin
                    r_x[i+1] <= r_x[i] + ys;
                    r_y[i+1] <= r_y[i] - xs;
                    r_z[i+1] <= r_z[i] + t;
                end
                r_zero[i+1] <= r_zero[i];
            end
        end
    end

    // exact zero angle gives exactly zero sine
    assign o_sine = r_zero[NUSED] ? '0 : r_y[NUSED][31:0];

endmodule

// ----- hw/rtl/ssi_div.sv -----
module ssi_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic               i_zero,
    input  logic signed [63:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_valid,
    output ssi_pkg::t_out      o_result
);

    localparam int QB = 31;

    typedef struct packed {
        logic zero;
        logic neg;
        logic ovf;
    } t_dtag;

    logic [63:0] num_mag;
    logic [31:0] den_mag;

    assign num_mag = i_num[63] ? 64'(-i_num) : 64'(i_num);
    assign den_mag = i_den[31] ? 32'(-i_den) : 32'(i_den);

    // stage a: magnitudes and sign
    logic        r_a_v;
    logic [62:0] r_a_num;
    logic [30:0] r_a_den;
    t_dtag       r_a_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else if (i_en) begin
            r_a_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_num      <= num_mag[62:0];
            r_a_den      <= den_mag[30:0];
            r_a_tag.zero <= i_zero;
            r_a_tag.neg  <= i_num[63] ^ i_den[31];
            r_a_tag.ovf  <= 1'b0;
        end
    end

    // restoring stages, quotient bit QB-1-j at stage j
    logic          r_v   [QB+1];
    logic [62:0]   r_rem [QB+1];
    logic [30:0]   r_d   [QB+1];
    logic [QB-1:0] r_q   [QB+1];
    t_dtag         r_tag [QB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= r_a_v;
        end
    end

    // quotient of 2^31 or more saturates either way
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]      <= r_a_num;
            r_d[0]        <= r_a_den;
            r_q[0]        <= '0;
            r_tag[0].zero <= r_a_tag.zero;
            r_tag[0].neg  <= r_a_tag.neg;
            r_tag[0].ovf  <= ({1'b0, r_a_num} >= {1'b0, r_a_den, 32'd0} >> 1);
        end
    end

    for (genvar j = 0; j < QB; j++) begin : g_bit
        localparam int K = QB - 1 - j;
        logic [63:0] dsh;
        logic        ge;

        assign dsh = 64'(r_d[j]) << K;
        assign ge  = ({1'b0, r_rem[j]} >= dsh);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= r_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= ge ? 63'({1'b0, r_rem[j]} - dsh) : r_rem[j];
                r_d[j+1]   <= r_d[j];
                r_q[j+1]   <= {r_q[j][QB-2:0], ge};
                r_tag[j+1] <= r_tag[j];
            end
        end
    end

    logic               r_out_v;
    ssi_pkg::t_out      r_out;
    logic signed [31:0] qs;

    assign qs = $signed({1'b0, r_q[QB]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_en) begin
            r_out_v <= r_v[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.sine_zero <= r_tag[QB].zero;
            priority if (r_tag[QB].zero) begin
                r_out.blended_value <= '0;
            end else if (r_tag[QB].ovf) begin
                r_out.blended_value <= r_tag[QB].neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
            end else begin
                r_out.blended_value <= r_tag[QB].neg ? -qs : qs;
            end
        end
    end

    assign o_valid  = r_out_v;
    assign o_result = r_out;

endmodule
